>>> hw/rtl/bda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package bda_pkg;

    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CHAR_W     = 6;
    localparam int ITER_W     = $clog2(BIN_W);
    localparam int POS_W      = $clog2(NUM_DIGITS);

    // ASCII code of '0'; the digit value is added to it.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Double dabble adds three to a digit of five or more before each shift.
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;

    typedef logic [BIN_W-1:0]                      value_t;
    typedef logic [DIGIT_W-1:0]                    digit_t;
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0]    bcd_t;
    typedef logic [CHAR_W-1:0]                     char_t;
    typedef logic [POS_W-1:0]                      pos_t;

endpackage

>>> hw/rtl/bda_queue.sv
// Short word queue between the accepting front and the conversion back end.
module bda_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bda_pkg::value_t in_value,
    output logic            out_valid,
    input  logic            out_ready,
    output bda_pkg::value_t out_value
);
    import bda_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    value_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_value = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_value;
        end
    end

    // The fill level tracks pushes and pops exactly and never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue fill level above depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill level missed a push");

endmodule

>>> hw/rtl/bda_conv.sv
// Iterative double dabble unit: one input bit per cycle into ten BCD digits.
module bda_conv (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bda_pkg::value_t in_value,
    output logic            out_valid,
    input  logic            out_ready,
    output bda_pkg::bcd_t   out_bcd
);
    import bda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    value_t            bin_reg, bin_next;
    bcd_t              bcd_reg, bcd_next;
    bcd_t              adj;
    logic [BCD_W-1:0]  adj_flat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign out_bcd   = bcd_reg;

    // Each digit is corrected on its own before the shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= DABBLE_LIMIT) ? bcd_reg[i] + DABBLE_ADD : bcd_reg[i];
        end
    end

    assign adj_flat = adj;

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    bin_next   = in_value;
                    bcd_next   = '0;
                    iter_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                bcd_next  = {adj_flat[BCD_W-2:0], bin_reg[BIN_W-1]};
                bin_next  = {bin_reg[BIN_W-2:0], 1'b0};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(BIN_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // A finished conversion holds only true decimal digits.
    a_digits_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |->
            (bcd_reg[0] <= DIGIT_MAX) && (bcd_reg[1] <= DIGIT_MAX) &&
            (bcd_reg[2] <= DIGIT_MAX) && (bcd_reg[3] <= DIGIT_MAX) &&
            (bcd_reg[4] <= DIGIT_MAX) && (bcd_reg[5] <= DIGIT_MAX) &&
            (bcd_reg[6] <= DIGIT_MAX) && (bcd_reg[7] <= DIGIT_MAX) &&
            (bcd_reg[8] <= DIGIT_MAX) && (bcd_reg[9] <= DIGIT_MAX))
        else $error("conversion produced a non-decimal digit");

    a_run_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && iter_reg == ITER_W'(BIN_W - 1)) |=> (state_reg == ST_DONE))
        else $error("conversion did not finish after the last bit");

endmodule

>>> hw/rtl/bda_emit.sv
// Digit sequencer: sends the significant BCD digits as ASCII, most significant first.
module bda_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bda_pkg::bcd_t        in_bcd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [5:0]           m_digit_char,
    output logic                 m_last_digit
);
    import bda_pkg::*;

    bcd_t  bcd_reg, bcd_next;
    pos_t  pos_reg, pos_next;
    logic  active_reg, active_next;
    logic  valid_reg, valid_next;
    char_t char_reg, char_next;
    logic  last_reg, last_next;
    pos_t  msd;
    logic  out_free;

    assign in_ready     = !active_reg;
    assign out_free     = !valid_reg || m_ready;
    assign m_valid      = valid_reg;
    assign m_digit_char = char_reg;
    assign m_last_digit = last_reg;

    // Highest nonzero digit; a zero value still sends its units digit.
    always_comb begin
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (in_bcd[i] != '0) begin
                msd = POS_W'(i);
            end
        end
    end

    always_comb begin
        bcd_next    = bcd_reg;
        pos_next    = pos_reg;
        active_next = active_reg;
        valid_next  = valid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (!active_reg) begin
            if (in_valid) begin
                bcd_next    = in_bcd;
                pos_next    = msd;
                active_next = 1'b1;
            end
        end
        if (out_free) begin
            valid_next = 1'b0;
            if (active_reg) begin
                valid_next = 1'b1;
                char_next  = ASCII_ZERO + CHAR_W'(bcd_reg[pos_reg]);
                last_next  = (pos_reg == '0);
                if (pos_reg == '0) begin
                    active_next = 1'b0;
                end else begin
                    pos_next = pos_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg  <= bcd_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // Every character sent is an ASCII decimal digit.
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (char_reg >= ASCII_ZERO) && (char_reg <= ASCII_ZERO + CHAR_W'(DIGIT_MAX)))
        else $error("character outside the decimal digit range");

endmodule

>>> hw/rtl/binary_to_decimal_ascii.sv
// Top level of the unsigned 32-bit binary to decimal ASCII converter.
//
// Input channel (s_valid, s_ready, s_value): one word is one 32-bit unsigned
// number. Output channel (m_valid, m_ready, m_digit_char, m_last_digit): one
// word is one ASCII digit character, 48 to 57. A number gives one to ten
// words, most significant digit first, without leading zeros; zero gives the
// single character '0'. m_last_digit is set on the units digit.
// Accepted numbers enter a short queue of QUEUE_DEPTH words. The conversion
// unit takes one number from it and runs double dabble, one input bit per
// cycle, then hands the ten BCD digits to the digit sequencer. The unit
// works on one number at a time and takes the next one only after the
// sequencer has taken its digits; the sequencer sends one digit per cycle
// while the receiver is ready, and the unit meanwhile works on the next
// number. When the receiver stalls, the current digit holds in the output
// register, the sequencer and then the conversion unit wait, and the queue
// keeps taking numbers until it is full. Synchronous active-low reset
// empties the queue and returns the unit and the sequencer to idle;
// nothing else resets.
module binary_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_digit_char,
    output logic        m_last_digit
);
    import bda_pkg::*;

    value_t q_value;
    logic   q_valid;
    logic   q_ready;
    bcd_t   conv_bcd;
    logic   conv_valid;
    logic   conv_ready;

    // Front: the queue takes words whenever it has room.
    bda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_value (q_value)
    );

    // Back: bit-serial conversion to BCD.
    bda_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_value  (q_value),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_bcd   (conv_bcd)
    );

    // Back: leading-zero suppression and ASCII output with a registered word.
    bda_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (conv_valid),
        .in_ready     (conv_ready),
        .in_bcd       (conv_bcd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

endmodule

>>> test/binary_to_decimal_ascii_test.sv
// Self-checking testbench for the binary to decimal ASCII converter.
module binary_to_decimal_ascii_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bda_pkg::*;

    // The expected digits come from dividing by the radix; each digit costs one division.
    localparam int RADIX          = 10;
    localparam int RANDOM_NUMBERS = 94;
    localparam int IDLE_PERCENT   = 19;
    localparam int MAX_REPORTS    = 10;
    // Long enough for the queue, the conversion unit and the sequencer to fill
    // up behind a stalled output, so that s_ready drops for a while.
    localparam int HOLD_CYCLES    = 250;
    // Waited after the last expected digit, to catch stray digits.
    localparam int DRAIN_CYCLES   = 45;

    // Holds the ASCII digits still owed by the block, in the order they must
    // come out, and checks each word leaving the output channel against them.
    class digit_string_board;
        char_t want_char[$];
        logic  want_last[$];
        int    mismatches = 0;

        function void flag(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s", $realtime, what);
            end
        endfunction

        // Splits an accepted number into decimal digits, units first, and
        // queues them most significant first. Zero still yields one digit.
        function void note_number(value_t num);
            digit_t rev[NUM_DIGITS];
            int     count;
            count = 0;
            do begin
                rev[count] = digit_t'(num % RADIX);
                num = num / RADIX;
                count++;
            end while (num != 0 && count < NUM_DIGITS);
            for (int k = count - 1; k >= 0; k--) begin
                want_char.push_back(char_t'(ASCII_ZERO + char_t'(rev[k])));
                want_last.push_back(k == 0);
            end
        endfunction

        function void check_digit(char_t got_char, logic got_last);
            char_t exp_char;
            logic  exp_last;
            if (want_char.size() == 0) begin
                flag($sformatf("unexpected digit char=%0d last=%0b", got_char, got_last));
                return;
            end
            exp_char = want_char.pop_front();
            exp_last = want_last.pop_front();
            if (got_char !== exp_char || got_last !== exp_last) begin
                flag($sformatf("digit mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
                               exp_char, exp_last, got_char, got_last));
            end
        endfunction

        function int outstanding();
            return want_char.size();
        endfunction
    endclass

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    value_t s_value = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    char_t  m_digit_char;
    logic   m_last_digit;

    // While calm is set neither side idles; hold_request asks the receiver
    // for one long stall.
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    digit_string_board board = new();

    binary_to_decimal_ascii dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

    always #5 aclk = ~aclk;

    // Picks a digit count first so that short and long numbers are equally
    // common; now and then a raw 32-bit word is used instead.
    function automatic value_t pick_number();
        int      ndig;
        longint  scale;
        longint  lo;
        longint  hi;
        ndig = $urandom_range(NUM_DIGITS + 1, 1);
        if (ndig > NUM_DIGITS) begin
            return $urandom;
        end
        scale = 1;
        repeat (ndig - 1) scale = scale * RADIX;
        lo = (ndig == 1) ? 0 : scale;
        hi = (ndig == NUM_DIGITS) ? 64'hFFFF_FFFF : scale * RADIX - 1;
        return $urandom_range(32'(hi), 32'(lo));
    endfunction

    // Called at a falling edge. Idles at random, then offers one word and
    // holds it until it is taken, and returns at the next falling edge.
    task automatic send_number(value_t num);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_value = num;
        do @(posedge aclk); while (!s_ready);
        board.note_number(num);
        @(negedge aclk);
    endtask

    // Receiver: random back-pressure at each falling edge, plus one long
    // stall whose length is counted here while the sender keeps offering.
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Every word leaving the output channel is checked at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_digit(m_digit_char, m_last_digit);
        end
    end

    initial begin
        // Zero, single digits, several decade boundaries that change the digit
        // count, the largest ten-digit values and alternating bit patterns.
        value_t directed[16] = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345,
            32'd999999999, 32'd1000000000, 32'd1234567890, 32'd2147483648,
            32'hAAAA_AAAA, 32'h5555_5555, 32'd4000000000, 32'd4294967294,
            32'd4294967295
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i]) begin
            send_number(directed[i]);
        end

        for (int i = 0; i < RANDOM_NUMBERS; i++) begin
            // A stretch with no idling on either side, then one long stall
            // of the receiver while numbers keep coming.
            calm = (i >= 30 && i < 55);
            if (i == 70) begin
                hold_request = 1'b1;
            end
            send_number(pick_number());
        end
        s_valid = 1'b0;
        calm = 1'b0;

        while (board.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatches == 0) begin
            $display("** binary_to_decimal_ascii: PASSED **");
        end else begin
            $display("** binary_to_decimal_ascii: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2ms;
        $display("** binary_to_decimal_ascii: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/bda_pkg.sv
hw/rtl/bda_queue.sv
hw/rtl/bda_conv.sv
hw/rtl/bda_emit.sv
hw/rtl/binary_to_decimal_ascii.sv
test/binary_to_decimal_ascii_test.sv
